// ===== rtl/lrfp_pkg.sv =====
package lrfp_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_NET_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PORTAL_MODE = 1'd1;

    localparam logic [2:0] EV_BEGIN      = 3'd0;
    localparam logic [2:0] EV_STA_START  = 3'd1;
    localparam logic [2:0] EV_DISCONNECT = 3'd2;
    localparam logic [2:0] EV_GOT_ADDR   = 3'd3;
    localparam logic [2:0] EV_HEALTH     = 3'd4;

    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_BACKOFF     = 3'd1;
    localparam logic [2:0] ACT_CONNECT_NET = 3'd2;
    localparam logic [2:0] ACT_GAVE_UP     = 3'd3;
    localparam logic [2:0] ACT_REBOOT      = 3'd4;
    localparam logic [2:0] ACT_CONNECT_NOW = 3'd5;
    localparam logic [2:0] ACT_LINKED      = 3'd6;

    localparam logic [15:0] MAX_RETRIES   = 16'd10;
    localparam logic [31:0] BASE_MS       = 32'd1000;
    localparam logic [31:0] CAP_MS        = 32'd60000;
    localparam logic [1:0]  TRIES_PER_NET = 2'd3;
    localparam logic [31:0] WINDOW_MS     = 32'd60000;
    localparam logic [15:0] STORM_LEVEL   = 16'd5;
    localparam logic [15:0] SHIFT_CAP     = 16'd16;
    localparam logic [3:0]  REBOOT_MISSES = 4'd10;

    localparam int DIVIDEND_W = 32;
    localparam int HALF_W     = 15;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [HALF_W-1:0]     divisor;
    } mod_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [HALF_W-1:0] rem;
    } mod_rsp_t;

    function automatic logic [HALF_W-1:0] half_of(input logic [15:0] attempt);
        logic [15:0] sh;
        logic [31:0] base;
        sh = (attempt == 16'd0) ? 16'd0 : attempt - 16'd1;
        if (sh > SHIFT_CAP)
        begin
            sh = SHIFT_CAP;
        end
        base = BASE_MS << sh[4:0];
        if (base > CAP_MS)
        begin
            base = CAP_MS;
        end
        return HALF_W'(base >> 1);
    endfunction

endpackage

// ===== rtl/lrfp_ifs.sv =====
interface lrfp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_req;
    logic [31:0] now_ms;
    logic [31:0] rand_word;

    modport source (output valid, output event_req, output now_ms, output rand_word,
                    input ready);
    modport sink (input valid, input event_req, input now_ms, input rand_word,
                  output ready);
endinterface

interface lrfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] delay_ms;
    logic [2:0]  net_index;
    logic        storm;
    logic        link_up;
    logic        given_up;
    logic [15:0] retry_count;
    logic [31:0] drop_total;
    logic [31:0] miss_total;

    modport source (output valid, output action, output delay_ms, output net_index,
                    output storm, output link_up, output given_up, output retry_count,
                    output drop_total, output miss_total, input ready);
    modport sink (input valid, input action, input delay_ms, input net_index,
                  input storm, input link_up, input given_up, input retry_count,
                  input drop_total, input miss_total, output ready);
endinterface

// ===== rtl/lrfp_mod_unit.sv =====
module lrfp_mod_unit
    import lrfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [HALF_W-1:0]     den_reg;
    logic [HALF_W-1:0]     rem_reg;

    logic [HALF_W:0]       trial;
    logic                  fits;
    logic [HALF_W-1:0]     rem_next;

    // One restoring step: bring in the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, num_reg[DIVIDEND_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? HALF_W'(trial - {1'b0, den_reg}) : trial[HALF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = busy_reg && (cnt_reg == '0);
    assign rsp.rem  = rem_next;

endmodule

// ===== rtl/link_reconnect_failover_policy.sv =====
// Channel  Role    Payload
// evt      sink    event_req, now_ms, rand_word
// act      source  action, delay_ms, net_index, storm, link_up, given_up,
//                  retry_count, drop_total, miss_total
//
// An event without backoff goes to pend_reg, then to out_reg once the output is free.
// A backoff event first waits for the 32-step serial remainder unit to set its delay.
// Reset clears all policy state and configuration; no clearing pass is needed.
// A new event is accepted while the previous result still waits in the output register.
// A stalled output holds the finished result and blocks only the next load.
module link_reconnect_failover_policy
    import lrfp_pkg::*;
#(
    parameter int NETS_MAX = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    lrfp_in_if.sink               evt,
    lrfp_out_if.source            act
);

    localparam int CW = $clog2(NETS_MAX);
    localparam logic [4:0] NetsMaxW = 5'(NETS_MAX);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_LOAD = 3'b100
    } seq_state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] delay_ms;
        logic [2:0]  net_index;
        logic        storm;
        logic        link_up;
        logic        given_up;
        logic [15:0] retry_count;
        logic [31:0] drop_total;
        logic [31:0] miss_total;
    } res_t;

    logic [3:0]    net_count_reg;
    logic          portal_reg;

    logic          linked_reg,    linked_next;
    logic          gave_up_reg,   gave_up_next;
    logic [15:0]   retries_reg,   retries_next;
    logic [1:0]    tries_reg,     tries_next;
    logic [CW-1:0] cur_net_reg,   cur_net_next;
    logic [31:0]   drops_reg,     drops_next;
    logic [31:0]   win_start_reg, win_start_next;
    logic [15:0]   streak_reg,    streak_next;
    logic [3:0]    hmiss_reg,     hmiss_next;
    logic [31:0]   misses_reg,    misses_next;

    seq_state_t    state_reg,     state_next;
    res_t          pend_reg,      pend_next;
    logic [HALF_W-1:0] half_reg,  half_next;
    logic          out_valid_reg;
    res_t          out_reg;

    logic [4:0]    n_avail;
    logic [2:0]    action_c;
    logic          backoff_c;
    logic [15:0]   attempt_c;
    logic [15:0]   streak_base;
    logic [1:0]    tries_inc;
    res_t          res_c;
    logic          accept;
    logic          out_free;
    mod_req_t      mod_req;
    mod_rsp_t      mod_rsp;

    assign evt.ready = (state_reg == ST_IDLE);
    assign accept    = evt.valid && evt.ready;
    assign out_free  = !out_valid_reg || act.ready;

    always_comb
    begin
        n_avail = ({1'b0, net_count_reg} > NetsMaxW) ? NetsMaxW : {1'b0, net_count_reg};

        linked_next    = linked_reg;
        gave_up_next   = gave_up_reg;
        retries_next   = retries_reg;
        tries_next     = tries_reg;
        cur_net_next   = cur_net_reg;
        drops_next     = drops_reg;
        win_start_next = win_start_reg;
        streak_next    = streak_reg;
        hmiss_next     = hmiss_reg;
        misses_next    = misses_reg;
        action_c       = ACT_NONE;
        backoff_c      = 1'b0;
        attempt_c      = 16'd0;
        streak_base    = streak_reg;
        tries_inc      = tries_reg;

        case (evt.event_req)
            EV_BEGIN:
            begin
                if (n_avail != 5'd0)
                begin
                    cur_net_next = '0;
                    tries_next   = 2'd0;
                    action_c     = ACT_CONNECT_NET;
                end
                else
                begin
                    retries_next = MAX_RETRIES;
                    gave_up_next = 1'b1;
                    action_c     = ACT_GAVE_UP;
                end
            end
            EV_STA_START:
            begin
                retries_next = 16'd0;
                gave_up_next = 1'b0;
            end
            EV_DISCONNECT:
            begin
                retries_next = (retries_reg == 16'hFFFF) ? retries_reg : retries_reg + 16'd1;
                drops_next   = (drops_reg == 32'hFFFF_FFFF) ? drops_reg : drops_reg + 32'd1;
                linked_next  = 1'b0;
                if ((evt.now_ms - win_start_reg) > WINDOW_MS)
                begin
                    win_start_next = evt.now_ms;
                    streak_base    = 16'd0;
                end
                streak_next = (streak_base == 16'hFFFF) ? streak_base : streak_base + 16'd1;
                if (gave_up_reg)
                begin
                    action_c = ACT_NONE;
                end
                else if (n_avail > 5'd1)
                begin
                    tries_inc  = (tries_reg < TRIES_PER_NET) ? tries_reg + 2'd1 : tries_reg;
                    tries_next = tries_inc;
                    if (tries_inc < TRIES_PER_NET)
                    begin
                        backoff_c = 1'b1;
                        attempt_c = {14'd0, tries_inc};
                    end
                    else if (5'(cur_net_reg) + 5'd1 < n_avail)
                    begin
                        cur_net_next = CW'(cur_net_reg + 1'b1);
                        tries_next   = 2'd0;
                        action_c     = ACT_CONNECT_NET;
                    end
                    else if (portal_reg)
                    begin
                        gave_up_next = 1'b1;
                        action_c     = ACT_GAVE_UP;
                    end
                    else
                    begin
                        cur_net_next = '0;
                        tries_next   = 2'd0;
                        action_c     = ACT_CONNECT_NET;
                    end
                end
                else if (portal_reg && (retries_next >= MAX_RETRIES))
                begin
                    gave_up_next = 1'b1;
                    action_c     = ACT_GAVE_UP;
                end
                else
                begin
                    backoff_c = 1'b1;
                    attempt_c = retries_next;
                end
            end
            EV_GOT_ADDR:
            begin
                retries_next = 16'd0;
                tries_next   = 2'd0;
                gave_up_next = 1'b0;
                linked_next  = 1'b1;
                action_c     = ACT_LINKED;
            end
            EV_HEALTH:
            begin
                if (linked_reg)
                begin
                    hmiss_next   = 4'd0;
                    gave_up_next = 1'b0;
                    retries_next = 16'd0;
                end
                else
                begin
                    hmiss_next  = (hmiss_reg == 4'hF) ? hmiss_reg : hmiss_reg + 4'd1;
                    misses_next = (misses_reg == 32'hFFFF_FFFF) ? misses_reg
                                                                : misses_reg + 32'd1;
                    if (hmiss_next >= REBOOT_MISSES)
                    begin
                        action_c = ACT_REBOOT;
                    end
                    else if (n_avail != 5'd0)
                    begin
                        action_c = ACT_CONNECT_NOW;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (backoff_c)
        begin
            action_c = ACT_BACKOFF;
        end

        res_c.action      = action_c;
        res_c.delay_ms    = 16'd0;
        res_c.net_index   = 3'(cur_net_next);
        res_c.storm       = streak_next >= STORM_LEVEL;
        res_c.link_up     = linked_next;
        res_c.given_up    = gave_up_next;
        res_c.retry_count = retries_next;
        res_c.drop_total  = drops_next;
        res_c.miss_total  = misses_next;
    end

    assign half_next        = half_of(attempt_c);
    assign mod_req.start    = accept && backoff_c;
    assign mod_req.dividend = evt.rand_word;
    assign mod_req.divisor  = half_next + 1'b1;

    lrfp_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next  = res_c;
                    state_next = backoff_c ? ST_DIV : ST_LOAD;
                end
            end
            ST_DIV:
            begin
                if (mod_rsp.done)
                begin
                    pend_next.delay_ms = {1'b0, half_reg} + {1'b0, mod_rsp.rem};
                    state_next         = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_count_reg <= 4'd0;
            portal_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NET_COUNT:   net_count_reg <= wr_data[3:0];
                REG_PORTAL_MODE: portal_reg    <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linked_reg    <= 1'b0;
            gave_up_reg   <= 1'b0;
            retries_reg   <= 16'd0;
            tries_reg     <= 2'd0;
            cur_net_reg   <= '0;
            drops_reg     <= 32'd0;
            win_start_reg <= 32'd0;
            streak_reg    <= 16'd0;
            hmiss_reg     <= 4'd0;
            misses_reg    <= 32'd0;
        end
        else if (accept)
        begin
            linked_reg    <= linked_next;
            gave_up_reg   <= gave_up_next;
            retries_reg   <= retries_next;
            tries_reg     <= tries_next;
            cur_net_reg   <= cur_net_next;
            drops_reg     <= drops_next;
            win_start_reg <= win_start_next;
            streak_reg    <= streak_next;
            hmiss_reg     <= hmiss_next;
            misses_reg    <= misses_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_LOAD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (act.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (accept)
        begin
            half_reg <= half_next;
        end
        if ((state_reg == ST_LOAD) && out_free)
        begin
            out_reg <= pend_reg;
        end
    end

    assign act.valid       = out_valid_reg;
    assign act.action      = out_reg.action;
    assign act.delay_ms    = out_reg.delay_ms;
    assign act.net_index   = out_reg.net_index;
    assign act.storm       = out_reg.storm;
    assign act.link_up     = out_reg.link_up;
    assign act.given_up    = out_reg.given_up;
    assign act.retry_count = out_reg.retry_count;
    assign act.drop_total  = out_reg.drop_total;
    assign act.miss_total  = out_reg.miss_total;

    // The remainder unit must be running for the whole wait for it.
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> mod_rsp.busy)
        else $error("sequencer waits on an idle remainder unit");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == ST_DIV))
        else $error("remainder finished outside the wait state");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LOAD) && out_free) |=> out_valid_reg)
        else $error("loaded result not presented");

    a_delay_only_backoff: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.action != ACT_BACKOFF)) |-> (out_reg.delay_ms == 16'd0))
        else $error("delay given with an action other than backoff");

    a_delay_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.delay_ms <= 16'(CAP_MS)))
        else $error("backoff delay above the cap");

endmodule

// ===== test/link_reconnect_failover_policy_tb.sv =====
`timescale 1ns / 1ps

module link_reconnect_failover_policy_tb
    import lrfp_pkg::*;
();

    localparam int NETS_MAX   = 8;
    localparam int IDLE_LIMIT = 3000;

    localparam logic [2:0] EV_SPARE_5 = 3'd5;
    localparam logic [2:0] EV_SPARE_6 = 3'd6;
    localparam logic [2:0] EV_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] delay_ms;
        logic [2:0]  net_index;
        logic        storm;
        logic        link_up;
        logic        given_up;
        logic [15:0] retry_count;
        logic [31:0] drop_total;
        logic [31:0] miss_total;
    } policy_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    lrfp_in_if evt();
    lrfp_out_if act();

    link_reconnect_failover_policy #(.NETS_MAX(NETS_MAX)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .evt      (evt),
        .act      (act)
    );

    always #1 clk = ~clk;

    // Policy state as the block should hold it.
    logic [3:0]  cfg_nets = '0;
    logic        cfg_portal = 1'b0;
    logic        pol_linked = 1'b0;
    logic        pol_gave_up = 1'b0;
    logic [15:0] pol_retries = '0;
    logic [1:0]  pol_tries = '0;
    logic [2:0]  pol_net = '0;
    logic [31:0] pol_drops = '0;
    logic [31:0] pol_window = '0;
    logic [15:0] pol_streak = '0;
    logic [3:0]  pol_health = '0;
    logic [31:0] pol_misses = '0;

    policy_result_t pending_results[$];
    int unsigned error_count = 0;
    int unsigned events_sent = 0;
    int unsigned settings_used = 0;
    int unsigned action_seen[8];
    int unsigned idle_cycles = 0;
    int unsigned hold_cycles = 0;
    bit idle_on = 1'b1;
    logic [31:0] clock_ms = '0;

    function automatic logic [15:0] jittered_delay(input logic [15:0] attempt,
                                                   input logic [31:0] rnd);
        int unsigned sh;
        longint unsigned base;
        int unsigned half;
        sh = (attempt > 0) ? attempt - 1 : 0;
        if (sh > SHIFT_CAP)
        begin
            sh = SHIFT_CAP;
        end
        base = longint'(BASE_MS) << sh;
        if (base > CAP_MS)
        begin
            base = CAP_MS;
        end
        half = int'(base / 2);
        return 16'(half + rnd % (half + 1));
    endfunction

    function automatic policy_result_t apply_policy_event(input logic [2:0] ev,
                                                          input logic [31:0] now,
                                                          input logic [31:0] rnd);
        policy_result_t r;
        int unsigned n;
        r = '0;
        r.action = ACT_NONE;
        n = (cfg_nets > NETS_MAX) ? NETS_MAX : cfg_nets;
        case (ev)
            EV_BEGIN:
            begin
                if (n > 0)
                begin
                    pol_net = '0;
                    pol_tries = '0;
                    r.action = ACT_CONNECT_NET;
                end
                else
                begin
                    pol_retries = MAX_RETRIES;
                    pol_gave_up = 1'b1;
                    r.action = ACT_GAVE_UP;
                end
            end
            EV_STA_START:
            begin
                pol_retries = '0;
                pol_gave_up = 1'b0;
            end
            EV_DISCONNECT:
            begin
                if (pol_retries != 16'hFFFF)
                begin
                    pol_retries++;
                end
                if (pol_drops != 32'hFFFF_FFFF)
                begin
                    pol_drops++;
                end
                pol_linked = 1'b0;
                if (32'(now - pol_window) > WINDOW_MS)
                begin
                    pol_window = now;
                    pol_streak = '0;
                end
                if (pol_streak != 16'hFFFF)
                begin
                    pol_streak++;
                end
                if (pol_gave_up)
                begin
                    r.action = ACT_NONE;
                end
                else if (n > 1)
                begin
                    if (pol_tries < TRIES_PER_NET)
                    begin
                        pol_tries++;
                    end
                    if (pol_tries < TRIES_PER_NET)
                    begin
                        r.action = ACT_BACKOFF;
                        r.delay_ms = jittered_delay(16'(pol_tries), rnd);
                    end
                    else if (int'(pol_net) + 1 < n)
                    begin
                        pol_net++;
                        pol_tries = '0;
                        r.action = ACT_CONNECT_NET;
                    end
                    else if (cfg_portal)
                    begin
                        pol_gave_up = 1'b1;
                        r.action = ACT_GAVE_UP;
                    end
                    else
                    begin
                        pol_net = '0;
                        pol_tries = '0;
                        r.action = ACT_CONNECT_NET;
                    end
                end
                else if (cfg_portal && pol_retries >= MAX_RETRIES)
                begin
                    pol_gave_up = 1'b1;
                    r.action = ACT_GAVE_UP;
                end
                else
                begin
                    r.action = ACT_BACKOFF;
                    r.delay_ms = jittered_delay(pol_retries, rnd);
                end
            end
            EV_GOT_ADDR:
            begin
                pol_retries = '0;
                pol_tries = '0;
                pol_gave_up = 1'b0;
                pol_linked = 1'b1;
                r.action = ACT_LINKED;
            end
            EV_HEALTH:
            begin
                if (pol_linked)
                begin
                    pol_health = '0;
                    pol_gave_up = 1'b0;
                    pol_retries = '0;
                end
                else
                begin
                    if (pol_health < 4'd15)
                    begin
                        pol_health++;
                    end
                    if (pol_misses != 32'hFFFF_FFFF)
                    begin
                        pol_misses++;
                    end
                    if (pol_health >= REBOOT_MISSES)
                    begin
                        r.action = ACT_REBOOT;
                    end
                    else if (n > 0)
                    begin
                        r.action = ACT_CONNECT_NOW;
                    end
                end
            end
            default:
            begin
                r.action = ACT_NONE;
            end
        endcase
        r.net_index = pol_net;
        r.storm = (pol_streak >= STORM_LEVEL);
        r.link_up = pol_linked;
        r.given_up = pol_gave_up;
        r.retry_count = pol_retries;
        r.drop_total = pol_drops;
        r.miss_total = pol_misses;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare every accepted result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        policy_result_t want;
        if (rst_n && act.valid && act.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual action %0d",
                         $time, act.action);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                action_seen[want.action]++;
                check_field("action", 32'(want.action), 32'(act.action));
                check_field("delay_ms", 32'(want.delay_ms), 32'(act.delay_ms));
                check_field("net_index", 32'(want.net_index), 32'(act.net_index));
                check_field("storm", 32'(want.storm), 32'(act.storm));
                check_field("link_up", 32'(want.link_up), 32'(act.link_up));
                check_field("given_up", 32'(want.given_up), 32'(act.given_up));
                check_field("retry_count", 32'(want.retry_count), 32'(act.retry_count));
                check_field("drop_total", want.drop_total, act.drop_total);
                check_field("miss_total", want.miss_total, act.miss_total);
            end
        end
    end

    // Result receiver: random stalls, plus an optional long hold-off.
    initial
    begin
        forever
        begin
            if (hold_cycles > 0)
            begin
                act.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                act.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                act.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((evt.valid && evt.ready) || (act.valid && act.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_event(input logic [2:0] ev, input logic [31:0] now,
                              input logic [31:0] rnd);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            evt.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        evt.valid <= 1'b1;
        evt.event_req <= ev;
        evt.now_ms <= now;
        evt.rand_word <= rnd;
        @(posedge clk);
        while (!evt.ready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(apply_policy_event(ev, now, rnd));
        events_sent++;
    endtask

    task automatic drain;
        evt.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_policy(input logic [3:0] nets, input logic portal);
        drain();
        wr_en <= 1'b1;
        wr_index <= REG_NET_COUNT;
        wr_data <= nets;
        @(posedge clk);
        wr_index <= REG_PORTAL_MODE;
        wr_data <= CFG_DATA_W'(portal);
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        cfg_nets = nets;
        cfg_portal = portal;
        settings_used++;
    endtask

    task automatic test_no_networks;
        set_policy(4'd0, 1'b0);
        send_event(EV_BEGIN, 32'd0, 32'd0);
        send_event(EV_SPARE_7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(EV_SPARE_5, 32'd50, 32'd7);
        send_event(EV_HEALTH, 32'd60, $urandom);
        send_event(EV_DISCONNECT, 32'd100, $urandom);
        send_event(EV_STA_START, 32'd150, $urandom);
        send_event(EV_DISCONNECT, 32'd200, 32'hFFFF_FFFF);
        send_event(EV_GOT_ADDR, 32'd300, $urandom);
        send_event(EV_HEALTH, 32'd400, $urandom);
    endtask

    task automatic test_failover_chain;
        set_policy(4'd3, 1'b1);
        send_event(EV_BEGIN, 32'd1000, $urandom);
        for (int i = 0; i < 9; i++)
        begin
            send_event(EV_DISCONNECT, 32'd2000 + 32'(i) * 32'd1000, $urandom);
        end
    endtask

    task automatic test_stale_index_and_wrap;
        set_policy(4'd2, 1'b0);
        send_event(EV_STA_START, 32'd20000, $urandom);
        send_event(EV_DISCONNECT, 32'd21000, 32'd0);
        send_event(EV_DISCONNECT, 32'hFFFF_FFF0, $urandom);
        send_event(EV_DISCONNECT, 32'd5, $urandom);
        send_event(EV_SPARE_6, 32'd6, $urandom);
    endtask

    task automatic random_event(output logic [2:0] ev);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            ev = EV_DISCONNECT;
        end
        else if (pick < 58)
        begin
            ev = EV_HEALTH;
        end
        else if (pick < 70)
        begin
            ev = EV_GOT_ADDR;
        end
        else if (pick < 80)
        begin
            ev = EV_BEGIN;
        end
        else if (pick < 90)
        begin
            ev = EV_STA_START;
        end
        else
        begin
            ev = 3'($urandom_range(5, 7));
        end
    endtask

    task automatic send_random_events(input int unsigned count);
        logic [2:0] ev;
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            random_event(ev);
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                clock_ms = clock_ms + $urandom_range(0, 20000);
            end
            else if (pick < 95)
            begin
                clock_ms = clock_ms + $urandom_range(60001, 200000);
            end
            else
            begin
                clock_ms = $urandom;
            end
            send_event(ev, clock_ms, $urandom);
        end
    endtask

    task automatic test_backpressure;
        set_policy(4'd4, 1'b0);
        idle_on = 1'b0;
        hold_cycles = 150;
        send_random_events(12);
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic;
        set_policy(4'd0, 1'b0);
        send_random_events(60);
        set_policy(4'd1, 1'b1);
        send_random_events(60);
        set_policy(4'd2, 1'b0);
        send_random_events(60);
        set_policy(4'd8, 1'b1);
        send_random_events(60);
        set_policy(4'd15, 1'b0);
        send_random_events(60);
        set_policy(4'd5, 1'b1);
        send_random_events(60);
        set_policy(4'd3, 1'b0);
        idle_on = 1'b0;
        send_random_events(60);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= '0;
        wr_data <= '0;
        evt.valid <= 1'b0;
        evt.event_req <= '0;
        evt.now_ms <= '0;
        evt.rand_word <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_networks();
        test_failover_chain();
        test_stale_index_and_wrap();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (40) @(posedge clk);
        $display("Covered %0d events under %0d register settings.", events_sent, settings_used);
        $display("Backoffs %0d, network switches %0d, give-ups %0d, reboots %0d, links %0d.",
                 action_seen[ACT_BACKOFF], action_seen[ACT_CONNECT_NET],
                 action_seen[ACT_GAVE_UP], action_seen[ACT_REBOOT], action_seen[ACT_LINKED]);
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
